// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/slde_pkg.sv
// ----------------------------------------------------------------------------
// Sync/length deframer package
// Types, register indexes and reset values shared by the deframer modules.
// ----------------------------------------------------------------------------
package slde_pkg;

    // Configuration register indexes.
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_VALUE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH = 1'b1;
    localparam int CfgDataW = 16;

    // Register reset values.
    localparam logic [7:0]  SYNC_VALUE_RST = 8'h3C;
    localparam logic [15:0] MAX_LENGTH_RST = 16'd172;

    // Default depth of the queue between parser and output stage.
    localparam int SLDE_QUEUE_DEPTH = 4;

    // Kind of result produced by the parser.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ABORT = 2'd2
    } t_slde_kind;

    // One classified result waiting in the queue.
    typedef struct packed {
        t_slde_kind kind;
        logic [7:0] data;
        logic       last;
        logic       first;
    } t_slde_item;

endpackage

// File: src/slde_front.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Holds the configuration registers and the header/payload state machine,
// and turns each accepted byte into at most one classified result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slde_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slde_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [slde_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                              i_accept,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              i_conn_reset,
    output logic                              o_push,
    output slde_pkg::t_slde_item              o_item
);
    import slde_pkg::*;

    typedef enum logic [3:0] {
        ST_HUNT = 4'b0001,
        ST_LOW  = 4'b0010,
        ST_HIGH = 4'b0100,
        ST_DATA = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_length_low, n_length_low;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic        r_spoke, n_spoke;
    logic [7:0]  r_sync_value;
    logic [15:0] r_max_length;

    logic [15:0] hdr_len;
    logic [15:0] seen_inc;
    logic        data_last;

    assign hdr_len   = {i_rx_byte, r_length_low};
    assign seen_inc  = r_bytes_seen + 16'd1;
    assign data_last = (seen_inc >= r_frame_length);

    always_comb begin
        n_state        = r_state;
        n_length_low   = r_length_low;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_spoke        = r_spoke;
        o_push         = 1'b0;
        o_item.kind    = KIND_DATA;
        o_item.data    = i_rx_byte;
        o_item.last    = 1'b0;
        o_item.first   = ~r_spoke;

        if (i_accept) begin
            if (i_conn_reset) begin
                // A frame whose payload already started is reported as cut off.
                if ((r_state == ST_DATA) && (r_bytes_seen != 16'd0)) begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_ABORT;
                end
                n_state        = ST_HUNT;
                n_length_low   = 8'd0;
                n_frame_length = 16'd0;
                n_bytes_seen   = 16'd0;
                n_spoke        = 1'b0;
            end else begin
                case (r_state)
                    ST_HUNT: begin
                        if (i_rx_byte == r_sync_value) begin
                            n_state = ST_LOW;
                        end
                    end
                    ST_LOW: begin
                        n_length_low = i_rx_byte;
                        n_state      = ST_HIGH;
                    end
                    ST_HIGH: begin
                        if (hdr_len > r_max_length) begin
                            // False sync: rescan the two length bytes.
                            if (r_length_low == r_sync_value) begin
                                n_length_low = i_rx_byte;
                                n_state      = ST_HIGH;
                            end else if (i_rx_byte == r_sync_value) begin
                                n_state = ST_LOW;
                            end else begin
                                n_state = ST_HUNT;
                            end
                        end else if (hdr_len == 16'd0) begin
                            o_push      = 1'b1;
                            o_item.kind = KIND_EMPTY;
                            o_item.last = 1'b1;
                            n_spoke     = 1'b1;
                            n_state     = ST_HUNT;
                        end else begin
                            n_frame_length = hdr_len;
                            n_bytes_seen   = 16'd0;
                            n_state        = ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        n_bytes_seen = seen_inc;
                        o_push       = 1'b1;
                        o_item.last  = data_last;
                        if (data_last) begin
                            n_spoke = 1'b1;
                            n_state = ST_HUNT;
                        end
                    end
                    default: begin
                        n_state = ST_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_HUNT;
            r_length_low   <= 8'd0;
            r_frame_length <= 16'd0;
            r_bytes_seen   <= 16'd0;
            r_spoke        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_length_low   <= n_length_low;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_spoke        <= n_spoke;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_VALUE_RST;
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_VALUE: r_sync_value <= i_cfg_data[7:0];
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Payload phase is only entered with a nonzero length and left on the last byte.
    `ASSERT_CLK(a_data_len_nonzero, i_clk, i_rst_n, (r_state != ST_DATA) || (r_frame_length != 16'd0), "payload phase with zero length")
    `ASSERT_CLK(a_data_seen_below, i_clk, i_rst_n, (r_state != ST_DATA) || (r_bytes_seen < r_frame_length), "payload count reached length without leaving payload phase")

endmodule

// File: src/slde_queue.sv
// ----------------------------------------------------------------------------
// Deframer result queue
// Small FIFO of classified results between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slde_queue #(
    parameter int DEPTH = slde_pkg::SLDE_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  slde_pkg::t_slde_item i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output slde_pkg::t_slde_item o_item
);
    import slde_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_slde_item    r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "request pushed into a full queue")
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(DEPTH), "queue count above depth")

endmodule

// File: src/slde_back.sv
// ----------------------------------------------------------------------------
// Deframer output stage
// Takes classified results from the queue, expands them into result fields
// and holds them in the output register until they are popped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slde_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  slde_pkg::t_slde_item i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_payload_byte,
    output logic                 o_is_last,
    output logic                 o_is_empty,
    output logic                 o_first_of_session,
    output logic                 o_aborted
);
    import slde_pkg::*;

    logic       r_valid;
    logic [7:0] r_payload_byte;
    logic       r_is_last, r_is_empty, r_first, r_aborted;
    logic [7:0] n_payload_byte;
    logic       n_is_last, n_is_empty, n_aborted;

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_payload_byte = 8'd0;
        n_is_last      = 1'b0;
        n_is_empty     = 1'b0;
        n_aborted      = 1'b0;
        case (i_q_item.kind)
            KIND_DATA: begin
                n_payload_byte = i_q_item.data;
                n_is_last      = i_q_item.last;
            end
            KIND_EMPTY: begin
                n_is_last  = 1'b1;
                n_is_empty = 1'b1;
            end
            KIND_ABORT: begin
                n_aborted = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_payload_byte <= n_payload_byte;
            r_is_last      <= n_is_last;
            r_is_empty     <= n_is_empty;
            r_first        <= i_q_item.first;
            r_aborted      <= n_aborted;
        end
    end

    assign o_empty            = !r_valid;
    assign o_payload_byte     = r_payload_byte;
    assign o_is_last          = r_is_last;
    assign o_is_empty         = r_is_empty;
    assign o_first_of_session = r_first;
    assign o_aborted          = r_aborted;

    // A waiting result in the queue fills an idle output register right away.
    `ASSERT_CLK(a_refill, i_clk, i_rst_n, (!r_valid && !i_q_empty) |=> r_valid, "output stage did not take a waiting result")

endmodule

// File: src/sync_length_deframer_top.sv
// ----------------------------------------------------------------------------
// Sync/length deframer, top level
// Finds sync + 16-bit little-endian length frames in a byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per request and sustains one byte per
// clock cycle in both directions while full is low and pop is high. Each
// byte is classified by the parser in the cycle it is accepted; a result it
// causes is written into a small queue and then into the output register
// driving the result ports, held there while pop is low. full rises only when
// the queue holds QUEUE_DEPTH results and the output register is occupied,
// so input keeps flowing while the consumer stalls. Frames start with the sync
// byte (register 0), then a length low and high byte; payload bytes are
// passed on one per result with the final one marked is_last. A length of
// zero gives a single marker with is_last and is_empty set. A length above
// max_length (register 1) is treated as a false sync and the two length
// bytes are rescanned as possible sync bytes. A request with conn_reset set
// ignores its data byte, restarts the session and, if payload of a frame
// was already passed on, gives one marker with aborted set. first_of_session
// stays set on results until the first frame of a session completes.
// Configuration must only be written while no results are pending.
// ----------------------------------------------------------------------------
module sync_length_deframer_top #(
    parameter int QUEUE_DEPTH = slde_pkg::SLDE_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [slde_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [slde_pkg::CfgDataW-1:0] i_cfg_data,
    // Input side.
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_conn_reset,
    // Result side.
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_is_last,
    output logic                          o_is_empty,
    output logic                          o_first_of_session,
    output logic                          o_aborted
);
    import slde_pkg::*;

    logic       accept;
    logic       f_push;
    t_slde_item f_item;
    logic       q_full, q_empty, q_pop;
    t_slde_item q_item;

    // A request is taken whenever the queue has room; the parser is never busy.
    assign full   = q_full;
    assign accept = push && !q_full;

    slde_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_rx_byte    (i_rx_byte),
        .i_conn_reset (i_conn_reset),
        .o_push       (f_push),
        .o_item       (f_item)
    );

    slde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // The output stage refills its register from the queue each cycle it is
    // free or its current result is being popped.
    slde_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_payload_byte     (o_payload_byte),
        .o_is_last          (o_is_last),
        .o_is_empty         (o_is_empty),
        .o_first_of_session (o_first_of_session),
        .o_aborted          (o_aborted)
    );

endmodule
